// ----- rtl/irf_pkg.sv -----
package irf_pkg;

  localparam int unsigned IdW            = 32;
  localparam int unsigned HandleW        = 16;
  localparam int unsigned WindowDepthDef = 16;
  localparam int unsigned MaxResults     = 16;
  localparam int unsigned CountW         = $clog2(MaxResults + 1);

  typedef struct packed {
    logic restart;
    logic capture;
    logic clr_step;
    logic store;
    logic clear_head;
    logic advance;
    logic load_in;
    logic load_ram;
    logic drop;
    logic push;
    logic push_last;
  } irf_cmd_t;

  typedef struct packed {
    logic in_win;
    logic is_head;
    logic rd_valid;
    logic cand_valid;
    logic out_free;
    logic clr_done;
  } irf_sts_t;

endpackage

// ----- rtl/in_order_frame_reorder.sv -----
// Frames arrive with a 32-bit sequence id and a 16-bit handle and leave strictly in id order.
// A frame at the expected id is released at once, followed by every stored frame with the
// next consecutive ids (at most 16 results per input beat), and the final result of a beat
// carries last. A frame ahead of the expected id within WINDOW_DEPTH is stored silently; a
// stale, too distant or duplicate frame comes back at once with status set. The block takes
// one input beat at a time: the handle store has one registered read port and is read once
// per drained frame, and a beat also waits out any stall on the output side. After reset
// and after every write of first_id, the store is cleared entry by entry, during which
// input is stalled.
module in_order_frame_reorder #(
  parameter int unsigned WINDOW_DEPTH = irf_pkg::WindowDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [irf_pkg::IdW-1:0]     cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [irf_pkg::IdW-1:0]     frame_id_i,
  input  logic [irf_pkg::HandleW-1:0] frame_handle_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [irf_pkg::IdW-1:0]     out_id_o,
  output logic [irf_pkg::HandleW-1:0] out_handle_o,
  output logic                        status_o,
  output logic                        last_o
);
  import irf_pkg::*;

  irf_cmd_t cmd;
  irf_sts_t sts;

  irf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_we_i   (cfg_we_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  irf_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .frame_id_i     (frame_id_i),
    .frame_handle_i (frame_handle_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_id_o       (out_id_o),
    .out_handle_o   (out_handle_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  // A new beat is only taken once every result of the previous one has left the holding stage.
  a_accept_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !sts.cand_valid)
    else $error("input beat accepted while a result is still held");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push_last && !cfg_we_i) |=> (!in_stall_o || cfg_we_i))
    else $error("block not ready after the final result of a beat");

  a_clear_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_head |-> sts.rd_valid)
    else $error("drain released an empty store entry");

endmodule

// ----- rtl/irf_ram.sv -----
module irf_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/irf_ctrl.sv -----
module irf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              cfg_we_i,
  input  irf_pkg::irf_sts_t sts_i,
  output irf_pkg::irf_cmd_t cmd_o,
  output logic              in_stall_o
);
  import irf_pkg::*;

  typedef enum logic [3:0] {
    StClear  = 4'b0001,
    StIdle   = 4'b0010,
    StLookup = 4'b0100,
    StDrain  = 4'b1000
  } irf_state_e;

  irf_state_e        state_q, state_d;
  logic [CountW-1:0] n_q, n_d;
  irf_cmd_t          cmd;

  assign in_stall_o = (state_q != StIdle) || cfg_we_i;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    n_d     = n_q;
    case (state_q)
      StClear: begin
        cmd.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i && !in_stall_o) begin
          cmd.capture = 1'b1;
          n_d         = '0;
          state_d     = StLookup;
        end
      end
      StLookup: begin
        if (!sts_i.in_win || sts_i.rd_valid) begin
          cmd.load_in = 1'b1;
          cmd.drop    = 1'b1;
          n_d         = CountW'(1);
        end else if (sts_i.is_head) begin
          cmd.load_in = 1'b1;
          cmd.advance = 1'b1;
          n_d         = CountW'(1);
        end else begin
          cmd.store = 1'b1;
        end
        state_d = StDrain;
      end
      StDrain: begin
        if ((n_q < CountW'(MaxResults)) && sts_i.rd_valid) begin
          if (!sts_i.cand_valid || sts_i.out_free) begin
            cmd.push       = sts_i.cand_valid;
            cmd.load_ram   = 1'b1;
            cmd.clear_head = 1'b1;
            cmd.advance    = 1'b1;
            n_d            = n_q + CountW'(1);
          end
        end else if (sts_i.cand_valid) begin
          if (sts_i.out_free) begin
            cmd.push      = 1'b1;
            cmd.push_last = 1'b1;
            state_d       = StIdle;
          end
        end else begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
    if (cfg_we_i) begin
      cmd.restart = 1'b1;
      state_d     = StClear;
    end
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

endmodule

// ----- rtl/irf_dpath.sv -----
module irf_dpath #(
  parameter int unsigned WINDOW_DEPTH = irf_pkg::WindowDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  irf_pkg::irf_cmd_t           cmd_i,
  output irf_pkg::irf_sts_t           sts_o,
  input  logic [irf_pkg::IdW-1:0]     frame_id_i,
  input  logic [irf_pkg::HandleW-1:0] frame_handle_i,
  input  logic [irf_pkg::IdW-1:0]     cfg_wdata_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [irf_pkg::IdW-1:0]     out_id_o,
  output logic [irf_pkg::HandleW-1:0] out_handle_o,
  output logic                        status_o,
  output logic                        last_o
);
  import irf_pkg::*;

  localparam int unsigned SlotW = $clog2(WINDOW_DEPTH);
  localparam int unsigned RamW  = HandleW + 1;

  logic [IdW-1:0]     expected_q;
  logic [SlotW-1:0]   head_q, head_d, head_inc;
  logic [SlotW-1:0]   clr_q;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic               in_win_q, is_head_q;
  logic [IdW-1:0]     in_id_q;
  logic [HandleW-1:0] in_handle_q;

  logic               cand_valid_q;
  logic [IdW-1:0]     cand_id_q;
  logic [HandleW-1:0] cand_handle_q;
  logic               cand_status_q;

  logic               out_valid_q;
  logic [IdW-1:0]     out_id_q;
  logic [HandleW-1:0] out_handle_q;
  logic               out_status_q;
  logic               out_last_q;

  logic [IdW-1:0]     off;
  logic [SlotW:0]     slot_sum, slot_wrap;
  logic               ram_we;
  logic [SlotW-1:0]   ram_waddr, ram_raddr;
  logic [RamW-1:0]    ram_wdata, ram_rdata;
  logic               out_free;

  assign off       = frame_id_i - expected_q;
  assign slot_sum  = {1'b0, head_q} + {1'b0, off[SlotW-1:0]};
  assign slot_wrap = (slot_sum >= (SlotW+1)'(WINDOW_DEPTH))
                   ? slot_sum - (SlotW+1)'(WINDOW_DEPTH) : slot_sum;
  assign slot_d    = slot_wrap[SlotW-1:0];

  assign head_inc = (head_q == SlotW'(WINDOW_DEPTH - 1)) ? '0 : head_q + SlotW'(1);

  always_comb begin
    head_d = head_q;
    if (cmd_i.restart) begin
      head_d = '0;
    end else if (cmd_i.advance) begin
      head_d = head_inc;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = '0;
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
    end else if (cmd_i.store) begin
      ram_we    = 1'b1;
      ram_waddr = slot_q;
      ram_wdata = {1'b1, in_handle_q};
    end else if (cmd_i.clear_head) begin
      ram_we    = 1'b1;
      ram_waddr = head_q;
    end
  end

  assign ram_raddr = cmd_i.capture ? slot_d : head_d;

  irf_ram #(
    .Width (RamW),
    .Depth (WINDOW_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o            = '0;
    sts_o.in_win     = in_win_q;
    sts_o.is_head    = is_head_q;
    sts_o.rd_valid   = ram_rdata[HandleW];
    sts_o.cand_valid = cand_valid_q;
    sts_o.out_free   = out_free;
    sts_o.clr_done   = (clr_q == SlotW'(WINDOW_DEPTH - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q   <= '0;
      head_q       <= '0;
      clr_q        <= '0;
      cand_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      if (cmd_i.restart) begin
        expected_q <= cfg_wdata_i;
      end else if (cmd_i.advance) begin
        expected_q <= expected_q + IdW'(1);
      end
      if (cmd_i.restart) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= (clr_q == SlotW'(WINDOW_DEPTH - 1)) ? '0 : clr_q + SlotW'(1);
      end
      if (cmd_i.restart) begin
        cand_valid_q <= 1'b0;
      end else if (cmd_i.load_in || cmd_i.load_ram) begin
        cand_valid_q <= 1'b1;
      end else if (cmd_i.push) begin
        cand_valid_q <= 1'b0;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_id_q     <= frame_id_i;
      in_handle_q <= frame_handle_i;
      in_win_q    <= (off < IdW'(WINDOW_DEPTH));
      is_head_q   <= (off == '0);
      slot_q      <= slot_d;
    end
    if (cmd_i.load_in) begin
      cand_id_q     <= in_id_q;
      cand_handle_q <= in_handle_q;
      cand_status_q <= cmd_i.drop;
    end else if (cmd_i.load_ram) begin
      cand_id_q     <= expected_q;
      cand_handle_q <= ram_rdata[HandleW-1:0];
      cand_status_q <= 1'b0;
    end
    if (cmd_i.push) begin
      out_id_q     <= cand_id_q;
      out_handle_q <= cand_handle_q;
      out_status_q <= cand_status_q;
      out_last_q   <= cmd_i.push_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_id_o     = out_id_q;
  assign out_handle_o = out_handle_q;
  assign status_o     = out_status_q;
  assign last_o       = out_last_q;

endmodule
